// ===== hdl/pqd_pkg.sv =====
// Package: shared types, constants and palette table for the palette quantizer.
`timescale 1ns / 1ps
package pqd_pkg;
    localparam int CacheEntries   = 512;
    localparam int PaletteEntries = 256;
    localparam int SlotW          = $clog2(CacheEntries);
    localparam int IdxW           = 8;
    localparam logic [7:0] TransparentIndex = 8'd255;
    localparam logic [17:0] BestDistInit    = 18'h3ffff;

    typedef struct packed {
        logic start;
        logic downsample;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] idx_tl;
        logic [7:0] idx_tr;
        logic [7:0] idx_bl;
        logic [7:0] idx_br;
    } pqd_cmd_t;

    typedef struct packed {
        logic done;
        logic [7:0] palette_index;
        logic cache_hit;
    } pqd_sts_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LOAD  = 6'b000010,
        ST_AVG   = 6'b000100,
        ST_LOOK  = 6'b001000,
        ST_WALK  = 6'b010000,
        ST_CLEAR = 6'b100000
    } pqd_state_t;

    function automatic logic [23:0] palette_color(input logic [7:0] i);
        logic [23:0] t [256];
        t = '{
  24'h000000, 24'hffffff, 24'h000010, 24'h000020, 24'h000030,
  24'h000040, 24'h000060, 24'h000080, 24'h0000a0, 24'h0000c0,
  24'h0000e0, 24'h0000ff, 24'h001000, 24'h001010, 24'h001800,
  24'h001818, 24'h001830, 24'h002000, 24'h002020, 24'h002040,
  24'h003000, 24'h003018, 24'h003030, 24'h003060, 24'h004000,
  24'h004020, 24'h004040, 24'h004080, 24'h0050a0, 24'h006000,
  24'h006030, 24'h006060, 24'h0060c0, 24'h0070e0, 24'h008000,
  24'h008040, 24'h008080, 24'h0080ff, 24'h009000, 24'h00a000,
  24'h00a050, 24'h00a0a0, 24'h00b6ff, 24'h00c000, 24'h00c060,
  24'h00c0c0, 24'h00e000, 24'h00e070, 24'h00e0e0, 24'h00ff00,
  24'h00ff80, 24'h00ffff, 24'h100000, 24'h100010, 24'h101000,
  24'h101010, 24'h103030, 24'h180000, 24'h181800, 24'h181830,
  24'h183000, 24'h183018, 24'h183030, 24'h200000, 24'h200020,
  24'h202000, 24'h202020, 24'h204000, 24'h204020, 24'h204040,
  24'h300000, 24'h300030, 24'h300c00, 24'h301800, 24'h301818,
  24'h302400, 24'h303000, 24'h303018, 24'h303030, 24'h303060,
  24'h306000, 24'h306030, 24'h306060, 24'h400000, 24'h400020,
  24'h400040, 24'h400080, 24'h401000, 24'h402000, 24'h402020,
  24'h402040, 24'h403000, 24'h404000, 24'h404020, 24'h404040,
  24'h404080, 24'h408000, 24'h408040, 24'h408080, 24'h486c6c,
  24'h5000a0, 24'h505050, 24'h5050a0, 24'h50a000, 24'h50a050,
  24'h50a0a0, 24'h600000, 24'h600030, 24'h600060, 24'h6000c0,
  24'h601800, 24'h603000, 24'h603030, 24'h603060, 24'h604800,
  24'h606000, 24'h606030, 24'h606060, 24'h606080, 24'h6060c0,
  24'h608060, 24'h608080, 24'h60c000, 24'h60c060, 24'h60c0c0,
  24'h6090b2, 24'h68541f, 24'h6c90b6, 24'h6cff00, 24'h7000e0,
  24'h707070, 24'h7070e0, 24'h70a0a0, 24'h70e000, 24'h70e070,
  24'h70e0e0, 24'h756958, 24'h7878a0, 24'h78a078, 24'h78a0a0,
  24'h800000, 24'h800040, 24'h800080, 24'h8000ff, 24'h802000,
  24'h804000, 24'h804040, 24'h804080, 24'h805a48, 24'h806000,
  24'h806060, 24'h806080, 24'h807020, 24'h808000, 24'h808040,
  24'h808060, 24'h808080, 24'h8080ff, 24'h80ff00, 24'h80ff80,
  24'h80ffff, 24'h904800, 24'h90876e, 24'h909090, 24'h9090c0,
  24'h90c090, 24'h90c0c0, 24'ha00000, 24'ha00050, 24'ha000a0,
  24'ha02800, 24'ha05000, 24'ha05050, 24'ha050a0, 24'ha07800,
  24'ha07878, 24'ha078a0, 24'ha0a000, 24'ha0a050, 24'ha0a078,
  24'ha0a0a0, 24'ha0a0e0, 24'ha57660, 24'ha8a8e0, 24'ha8e0a8,
  24'ha8e0e0, 24'haa8834, 24'haa9a80, 24'hb0b0b0, 24'hb24000,
  24'hb64800, 24'hc00000, 24'hc00060, 24'hc000c0, 24'hc03000,
  24'hc06000, 24'hc06060, 24'hc060c0, 24'hc09000, 24'hc09090,
  24'hc090c0, 24'hc0a040, 24'hc0c000, 24'hc0c060, 24'hc0c090,
  24'hc0c0c0, 24'hc0c0ff, 24'hc0ffc0, 24'hc0ffff, 24'hca9072,
  24'hd0a850, 24'hd0d0d0, 24'hd2d2b2, 24'hdadab6, 24'he00000,
  24'he00070, 24'he000e0, 24'he03800, 24'he07000, 24'he07070,
  24'he070e0, 24'he0a800, 24'he0a8a8, 24'he0a8e0, 24'he0c0a0,
  24'he0e000, 24'he0e070, 24'he0e0a8, 24'he0e0e0, 24'he5a282,
  24'hf0f0f0, 24'hf20000, 24'hf26000, 24'hf2c44d, 24'hf8e060,
  24'hfcfc99, 24'hff0000, 24'hff0080, 24'hff00ff, 24'hff4000,
  24'hff6c00, 24'hff8000, 24'hff8080, 24'hff80ff, 24'hffb690,
  24'hffc000, 24'hffc0c0, 24'hffc0ff, 24'hffd3b0, 24'hffff00,
  24'hffff80, 24'hffffc0, 24'h102030, 24'h301800, 24'h282828,
  24'h000000};
        return t[i];
    endfunction
endpackage

// ===== hdl/pqd_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module pqd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/pqd_ctrl.sv =====
// Controller state machine of the palette quantizer.
`timescale 1ns / 1ps
module pqd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 transparent,
    input  logic                 lookup_hit,
    input  logic                 walk_done,
    input  logic                 clear_done,
    output pqd_pkg::pqd_state_t  state
);
    import pqd_pkg::*;

    pqd_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clear_done) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_AVG;
            ST_AVG:   state_next = transparent ? ST_IDLE : ST_LOOK;
            ST_LOOK:  state_next = lookup_hit ? ST_IDLE : ST_WALK;
            ST_WALK:  if (walk_done) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;
endmodule

// ===== hdl/pqd_datapath.sv =====
// Datapath: averaging, cache lookup and palette walk.
`timescale 1ns / 1ps
module pqd_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  pqd_pkg::pqd_state_t state,
    input  pqd_pkg::pqd_cmd_t   cmd,
    input  logic [8:0]          alpha_threshold,
    output logic                transparent,
    output logic                lookup_hit,
    output logic                walk_done,
    output logic                clear_done,
    output pqd_pkg::pqd_sts_t   sts
);
    import pqd_pkg::*;

    logic [SlotW-1:0] clr_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic        trans_reg;
    logic [9:0]  rs_reg, gs_reg, bs_reg;
    logic [2:0]  n_reg;
    logic [7:0]  i_reg, best_reg;
    logic [17:0] bdist_reg;
    logic        done_reg, hit_reg;
    logic [7:0]  out_reg;
    logic [SlotW-1:0] slot_reg;

    logic [23:0] p0, p1, p2, p3, pw;
    logic [7:0]  ar, ag, ab;
    logic [SlotW+5:0] hsum;
    logic        we;
    logic [SlotW-1:0] addr;
    logic [32:0] wdata, rdata;
    logic [8:0]  dr, dg, db;
    logic [17:0] cur_err;
    logic        last;

    // downsample: read the four palette colors
    always_comb begin
        p0 = palette_color(cmd.idx_tl);
        p1 = palette_color(cmd.idx_tr);
        p2 = palette_color(cmd.idx_bl);
        p3 = palette_color(cmd.idx_br);
    end

    // truncated mean over 1..4 opaque pixels: divide by 3 via reciprocal
    function automatic logic [7:0] mean_of(input logic [9:0] s, input logic [2:0] n);
        logic [20:0] q;
        q = 21'(s) * 21'd683;
        case (n)
            3'd1:    mean_of = s[7:0];
            3'd2:    mean_of = s[8:1];
            3'd3:    mean_of = q[18:11];
            default: mean_of = s[9:2];
        endcase
    endfunction

    assign ar = mean_of(rs_reg, n_reg);
    assign ag = mean_of(gs_reg, n_reg);
    assign ab = mean_of(bs_reg, n_reg);
    assign hsum = (SlotW+6)'(ag) + (SlotW+6)'(ar) * (SlotW+6)'(11)
                + (SlotW+6)'(ab) * (SlotW+6)'(41);

    assign pw = palette_color(i_reg);
    always_comb begin
        dr = (r_reg > pw[23:16]) ? 9'(r_reg - pw[23:16]) : 9'(pw[23:16] - r_reg);
        dg = (g_reg > pw[15:8])  ? 9'(g_reg - pw[15:8])  : 9'(pw[15:8] - g_reg);
        db = (b_reg > pw[7:0])   ? 9'(b_reg - pw[7:0])   : 9'(pw[7:0] - b_reg);
        cur_err = 18'(dr) * 18'(dr) + 18'(dg) * 18'(dg) + 18'(db) * 18'(db);
    end
    assign last = (i_reg == 8'(PaletteEntries - 1)) || (cur_err == 18'd0);

    assign lookup_hit  = rdata[32] && (rdata[31:8] == {r_reg, g_reg, b_reg});
    assign walk_done   = last;
    assign transparent = trans_reg;
    assign clear_done  = (clr_reg == SlotW'(CacheEntries - 1));

    always_comb begin
        we = 1'b0;
        addr = slot_reg;
        wdata = {1'b1, r_reg, g_reg, b_reg, best_reg};
        if (state == ST_CLEAR) begin
            we = 1'b1;
            addr = clr_reg;
            wdata = '0;
        end else if (state == ST_AVG) begin
            addr = hsum[SlotW-1:0];
        end else if (state == ST_WALK && last) begin
            we = 1'b1;
            if (cur_err == 18'd0 || (i_reg != TransparentIndex && cur_err < bdist_reg)) begin
                wdata[7:0] = i_reg;
            end
        end
    end

    pqd_ram #(.Width(33), .Depth(CacheEntries)) u_cache (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (state == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if ((state == ST_AVG && trans_reg) || (state == ST_LOOK && lookup_hit)
                || (state == ST_WALK && last)) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state)
            ST_IDLE: begin
                i_reg <= '0;
            end
            ST_LOAD: begin
                if (cmd.downsample) begin
                    rs_reg <= 10'((cmd.idx_tl != TransparentIndex) ? p0[23:16] : 8'd0)
                            + 10'((cmd.idx_tr != TransparentIndex) ? p1[23:16] : 8'd0)
                            + 10'((cmd.idx_bl != TransparentIndex) ? p2[23:16] : 8'd0)
                            + 10'((cmd.idx_br != TransparentIndex) ? p3[23:16] : 8'd0);
                    gs_reg <= 10'((cmd.idx_tl != TransparentIndex) ? p0[15:8] : 8'd0)
                            + 10'((cmd.idx_tr != TransparentIndex) ? p1[15:8] : 8'd0)
                            + 10'((cmd.idx_bl != TransparentIndex) ? p2[15:8] : 8'd0)
                            + 10'((cmd.idx_br != TransparentIndex) ? p3[15:8] : 8'd0);
                    bs_reg <= 10'((cmd.idx_tl != TransparentIndex) ? p0[7:0] : 8'd0)
                            + 10'((cmd.idx_tr != TransparentIndex) ? p1[7:0] : 8'd0)
                            + 10'((cmd.idx_bl != TransparentIndex) ? p2[7:0] : 8'd0)
                            + 10'((cmd.idx_br != TransparentIndex) ? p3[7:0] : 8'd0);
                    n_reg <= 3'd4 - 3'(cmd.idx_tl == TransparentIndex)
                           - 3'(cmd.idx_tr == TransparentIndex)
                           - 3'(cmd.idx_bl == TransparentIndex)
                           - 3'(cmd.idx_br == TransparentIndex);
                    trans_reg <= (3'(cmd.idx_tl == TransparentIndex)
                           + 3'(cmd.idx_tr == TransparentIndex)
                           + 3'(cmd.idx_bl == TransparentIndex)
                           + 3'(cmd.idx_br == TransparentIndex)) > 3'd2;
                end else begin
                    rs_reg <= 10'(cmd.red);
                    gs_reg <= 10'(cmd.green);
                    bs_reg <= 10'(cmd.blue);
                    n_reg  <= 3'd1;
                    trans_reg <= 9'(cmd.alpha) < alpha_threshold;
                end
            end
            ST_AVG: begin
                r_reg <= ar;
                g_reg <= ag;
                b_reg <= ab;
                slot_reg <= hsum[SlotW-1:0];
                best_reg <= '0;
                bdist_reg <= BestDistInit;
                out_reg <= TransparentIndex;
                hit_reg <= 1'b0;
            end
            ST_LOOK: begin
                out_reg <= rdata[7:0];
                hit_reg <= lookup_hit;
            end
            ST_WALK: begin
                i_reg <= i_reg + 1'b1;
                if (i_reg != TransparentIndex && (cur_err == 18'd0 || cur_err < bdist_reg)) begin
                    best_reg  <= i_reg;
                    bdist_reg <= cur_err;
                end
                if (last) begin
                    out_reg <= (i_reg != TransparentIndex
                               && (cur_err == 18'd0 || cur_err < bdist_reg)) ? i_reg : best_reg;
                end
            end
            default: begin
                n_reg <= n_reg;
            end
        endcase
    end

    assign sts.done          = done_reg;
    assign sts.palette_index = out_reg;
    assign sts.cache_hit     = hit_reg;
endmodule

// ===== hdl/palette_quantizer_with_downsample_core.sv =====
// Top level: stream wrapper around controller and datapath.
`timescale 1ns / 1ps
// Transparent results end after averaging, hits after lookup, misses after the walk.
// Throughput: one request at a time; a miss walks the palette one entry a cycle,
// and the next request waits until the previous result has been taken.
// Reset (aresetn low, synchronous): threshold returns to 128 and a clearing
// pass over all 512 entries wipes the match cache before the first request.
module palette_quantizer_with_downsample_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: red, green, blue, alpha, tl, tr, bl, br (lowest bit up)
    input  logic [63:0] s_tdata,
    // tuser: command
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: palette_index
    output logic [7:0]  m_tdata,
    // tuser: cache_hit
    output logic [0:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data
);
    import pqd_pkg::*;

    pqd_state_t state;
    pqd_cmd_t   cmd_reg;
    pqd_sts_t   sts;
    logic [8:0] thr_reg;
    logic       ovalid_reg;
    logic [7:0] oidx_reg;
    logic       ohit_reg;
    logic       transparent, lookup_hit, walk_done, clear_done;

    // Take a request only when idle and the result slot is empty, so a
    // finished result never lands on one that still waits for the sink.
    assign s_tready  = (state == ST_IDLE) && !cmd_reg.start && !sts.done && !ovalid_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= 9'd128;
            cmd_reg.start <= 1'b0;
            ovalid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) thr_reg <= cfg_data;
            cmd_reg.start <= s_tvalid && s_tready;
            // payload capture
            if (s_tvalid && s_tready) begin
                cmd_reg.downsample <= s_tuser[0];
                cmd_reg.red    <= s_tdata[7:0];
                cmd_reg.green  <= s_tdata[15:8];
                cmd_reg.blue   <= s_tdata[23:16];
                cmd_reg.alpha  <= s_tdata[31:24];
                cmd_reg.idx_tl <= s_tdata[39:32];
                cmd_reg.idx_tr <= s_tdata[47:40];
                cmd_reg.idx_bl <= s_tdata[55:48];
                cmd_reg.idx_br <= s_tdata[63:56];
            end
            // hold a finished result until the sink takes it
            if (sts.done) begin
                ovalid_reg <= 1'b1;
            end else if (m_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (sts.done) begin
            oidx_reg <= sts.palette_index;
            ohit_reg <= sts.cache_hit;
        end
    end

    pqd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(cmd_reg.start),
        .transparent(transparent), .lookup_hit(lookup_hit),
        .walk_done(walk_done), .clear_done(clear_done), .state(state)
    );

    pqd_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .state(state), .cmd(cmd_reg),
        .alpha_threshold(thr_reg), .transparent(transparent),
        .lookup_hit(lookup_hit), .walk_done(walk_done),
        .clear_done(clear_done), .sts(sts)
    );

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = oidx_reg;
    assign m_tuser  = ohit_reg;
endmodule

// ===== hdl/pqd_checker.sv =====
// Port-level checker for the palette quantizer, bound to the top level.
`timescale 1ns / 1ps
module pqd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken during work");
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 !($rose(m_tvalid)))
        else $error("result too early");
    a_hit_not_transp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata != 8'd255)
        else $error("hit on transparent");
endmodule

bind palette_quantizer_with_downsample_core pqd_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
